### hdl/string_id_multiplicative_hash_core_assert.svh
// ----------------------------------------------------------------------------
// String id hash: assertion macros
// Shared concurrent assertion forms for the string id hash core.
// ----------------------------------------------------------------------------
`ifndef STRING_ID_MULTIPLICATIVE_HASH_CORE_ASSERT_SVH
`define STRING_ID_MULTIPLICATIVE_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SIDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SIDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sidh_pkg.sv
// ----------------------------------------------------------------------------
// String id hash package
// Request types, hash constants, state encodings and mask helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sidh_pkg;

    // Word limit per name
    localparam int MAX_WORDS = 64;
    localparam int WORDS_W   = $clog2(MAX_WORDS + 1);

    // Hash constants
    localparam logic [31:0] PAD_WORD_A = 32'h9BE7_4448;
    localparam logic [31:0] PAD_WORD_B = 32'h66F4_2C48;
    localparam logic [31:0] KEY_INIT   = 32'hF4FA_8928;
    localparam logic [31:0] X_INIT     = 32'h37A8_470E;
    localparam logic [31:0] Y_INIT     = 32'h7758_B42B;
    localparam logic [31:0] KEY_XOR    = 32'h267B_0B11;
    localparam logic [31:0] X_OR_MASK  = 32'h0204_0801;
    localparam logic [31:0] X_AND_MASK = 32'hBFEF_7FDF;
    localparam logic [31:0] Y_OR_MASK  = 32'h0080_4021;
    localparam logic [31:0] Y_AND_MASK = 32'h7DFE_FBFF;

    // Byte codes used by case folding
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_CASE    = 8'h20;
    localparam logic [7:0] CHR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;

    typedef struct packed {
        logic [31:0] name_word;
        logic        word_empty;
        logic        last_word;
    } t_sidh_in;

    typedef struct packed {
        logic [31:0] name_id;
        logic        too_long;
    } t_sidh_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_FOLD_X,
        S_MUL_Y,
        S_FOLD_Y,
        S_PAD,
        S_EMIT
    } t_sidh_state;

    typedef enum logic [1:0] {
        RND_DATA,
        RND_PAD_A,
        RND_PAD_B
    } t_sidh_round;

    // Multiplier operand masks
    function automatic logic [31:0] mask_x(input logic [31:0] v);
        mask_x = (v | X_OR_MASK) & X_AND_MASK;
    endfunction

    function automatic logic [31:0] mask_y(input logic [31:0] v);
        mask_y = (v | Y_OR_MASK) & Y_AND_MASK;
    endfunction

endpackage

`default_nettype wire

### hdl/string_id_multiplicative_hash_core.sv
// ----------------------------------------------------------------------------
// String id multiplicative hash core
// Operation: a word is taken, then the block stalls while the shared
//   32x32 multiplier runs the x and y halves of its round (mul, fold, each).
// A last item then runs two pad rounds and a result load, which waits on a
//   stalled output; an item whose word is empty or not taken skips its round.
// Reset (synchronous, active low) clears the accumulators, key and counters
//   to their start values, empties the output register and clears the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module string_id_multiplicative_hash_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sidh_pkg::t_sidh_in  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output sidh_pkg::t_sidh_out    o_out_req
);

    import sidh_pkg::*;

    // Control and name state
    t_sidh_state         r_state, n_state;
    logic                r_fold, n_fold;
    logic [31:0]         r_x, n_x;
    logic [31:0]         r_y, n_y;
    logic [31:0]         r_key, n_key;
    logic [WORDS_W-1:0]  r_words, n_words;
    logic                r_ovf, n_ovf;
    logic                r_ended, n_ended;
    logic                r_out_valid, n_out_valid;

    // Round payload
    logic [31:0]         r_w, n_w;
    logic [31:0]         r_t, n_t;
    logic [63:0]         r_prod, n_prod;
    t_sidh_round         r_round, n_round;
    logic                r_last, n_last;
    t_sidh_out           r_out, n_out;

    logic                in_acc;
    logic [31:0]         prep_word;
    logic                prep_nul;
    logic [31:0]         pre_word;
    logic [31:0]         pre_rot;
    logic [31:0]         pre_w;
    logic [31:0]         pre_x;
    logic [31:0]         pre_y;
    logic [31:0]         mul_a;
    logic [63:0]         mul_prod;
    logic [31:0]         fold_x;
    logic [31:0]         fold_y;
    logic                out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Case folding (when enabled) and cut at the first NUL byte
    always_comb begin
        logic       alive;
        logic [7:0] b;
        alive     = 1'b1;
        prep_word = '0;
        prep_nul  = 1'b0;
        for (int k = 0; k < 4; k++) begin
            b = i_in_req.name_word[8*k +: 8];
            if (b == 8'h00) begin
                alive    = 1'b0;
                prep_nul = 1'b1;
            end
            if (r_fold) begin
                if (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) begin
                    b = b + CHR_CASE;
                end else if (b == CHR_BSLASH) begin
                    b = CHR_SLASH;
                end
            end
            prep_word[8*k +: 8] = alive ? b : 8'h00;
        end
    end

    // Round setup: key rotate, word mixed into both accumulators
    assign pre_word = (r_state == S_PAD) ?
                      ((r_round == RND_DATA) ? PAD_WORD_A : PAD_WORD_B) : prep_word;
    assign pre_rot  = {r_key[30:0], r_key[31]};
    assign pre_w    = KEY_XOR ^ pre_rot;
    assign pre_x    = r_x ^ pre_word;
    assign pre_y    = r_y ^ pre_word;

    // Shared multiplier and the two folds
    assign mul_a    = (r_state == S_MUL_X) ? r_x : r_y;
    assign mul_prod = {32'h0, mul_a} * {32'h0, r_t};
    assign fold_x   = r_prod[31:0] + r_prod[63:32] + {31'h0, r_prod[32]};
    assign fold_y   = r_prod[31:0] + {r_prod[62:32], 1'b0} + {30'h0, r_prod[31], 1'b0};

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_fold      = i_cfg_we ? i_cfg_wdata : r_fold;
        n_x         = r_x;
        n_y         = r_y;
        n_key       = r_key;
        n_words     = r_words;
        n_ovf       = r_ovf;
        n_ended     = r_ended;
        n_out_valid = r_out_valid && i_out_stall;
        n_w         = r_w;
        n_t         = r_t;
        n_prod      = r_prod;
        n_round     = r_round;
        n_last      = r_last;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_req.last_word;
                    if (!i_in_req.word_empty && !r_ended &&
                        i_in_req.name_word[7:0] == 8'h00) begin
                        n_ended = 1'b1;
                    end
                    if (!i_in_req.word_empty && !r_ended &&
                        i_in_req.name_word[7:0] != 8'h00 &&
                        r_words >= WORDS_W'(MAX_WORDS)) begin
                        n_ovf = 1'b1;
                    end
                    if (!i_in_req.word_empty && !r_ended &&
                        i_in_req.name_word[7:0] != 8'h00 &&
                        r_words < WORDS_W'(MAX_WORDS)) begin
                        n_key   = pre_rot;
                        n_w     = pre_w;
                        n_x     = pre_x;
                        n_y     = pre_y;
                        n_t     = mask_x(pre_w + pre_y);
                        n_words = r_words + WORDS_W'(1);
                        n_round = RND_DATA;
                        n_state = S_MUL_X;
                        if (prep_nul) begin
                            n_ended = 1'b1;
                        end
                    end else if (i_in_req.last_word) begin
                        n_round = RND_DATA;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_key   = pre_rot;
                n_w     = pre_w;
                n_x     = pre_x;
                n_y     = pre_y;
                n_t     = mask_x(pre_w + pre_y);
                n_round = (r_round == RND_DATA) ? RND_PAD_A : RND_PAD_B;
                n_state = S_MUL_X;
            end
            S_MUL_X: begin
                n_prod  = mul_prod;
                n_state = S_FOLD_X;
            end
            S_FOLD_X: begin
                n_x     = fold_x;
                n_t     = mask_y(r_w + fold_x);
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                n_prod  = mul_prod;
                n_state = S_FOLD_Y;
            end
            S_FOLD_Y: begin
                n_y = fold_y;
                unique case (r_round)
                    RND_DATA:  n_state = r_last ? S_PAD : S_IDLE;
                    RND_PAD_A: n_state = S_PAD;
                    RND_PAD_B: n_state = S_EMIT;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.name_id  = r_x ^ r_y;
                    n_out.too_long = r_ovf;
                    n_out_valid    = 1'b1;
                    n_x            = X_INIT;
                    n_y            = Y_INIT;
                    n_key          = KEY_INIT;
                    n_words        = '0;
                    n_ovf          = 1'b0;
                    n_ended        = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and name state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fold      <= 1'b0;
            r_x         <= X_INIT;
            r_y         <= Y_INIT;
            r_key       <= KEY_INIT;
            r_words     <= '0;
            r_ovf       <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fold      <= n_fold;
            r_x         <= n_x;
            r_y         <= n_y;
            r_key       <= n_key;
            r_words     <= n_words;
            r_ovf       <= n_ovf;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_t     <= n_t;
        r_prod  <= n_prod;
        r_round <= n_round;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Checks
`include "string_id_multiplicative_hash_core_assert.svh"

    `SIDH_ASSERT_NOW(a_words_bound, i_clk, i_rst_n, 1'b1, r_words <= WORDS_W'(MAX_WORDS), "word count past limit")
    `SIDH_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_state == S_EMIT && out_free, r_out_valid && r_state == S_IDLE && r_words == '0 && !r_ovf, "result load did not clear name")
    `SIDH_ASSERT_NEXT(a_pad_b_emit, i_clk, i_rst_n, r_state == S_FOLD_Y && r_round == RND_PAD_B, r_state == S_EMIT, "pad rounds did not end in emit")
    `SIDH_ASSERT_NEXT(a_empty_last, i_clk, i_rst_n, in_acc && i_in_req.last_word && (i_in_req.word_empty || r_ended), r_state == S_PAD && r_round == RND_DATA, "last request without word skipped pads")

endmodule

`default_nettype wire
